// ===== src/delimited_text_field_tokenizer_core_assert.svh =====
// Assertion macros for the delimited text tokenizer checker.
// No dependencies; take in by `include where assertions are written.
`ifndef DELIMITED_TEXT_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define DELIMITED_TEXT_FIELD_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DTFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DTFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ===== src/dtft_pkg.sv =====
// Shared types and constants of the delimited text tokenizer.
// No dependencies.
package dtft_pkg;

    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FLD_SEP        = 3'd0,
        REG_COLL_SEP       = 3'd1,
        REG_RECORD_DELIM   = 3'd2,
        REG_ESCAPE_BYTE    = 3'd3,
        REG_QUOTE_BYTE     = 3'd4,
        REG_QUOTES_ENABLED = 3'd5,
        REG_KEPT_COLUMNS   = 3'd6
    } t_reg_idx;

    localparam logic [7:0]  RST_FLD_SEP          = 8'd44;
    localparam logic [7:0]  RST_COLL_SEP         = 8'd44;
    localparam logic [7:0]  RST_RECORD_DELIM     = 8'd10;
    localparam logic [7:0]  RST_ESCAPE_BYTE      = 8'd92;
    localparam logic [7:0]  RST_QUOTE_BYTE       = 8'd34;
    localparam logic        RST_QUOTES_ENABLED   = 1'b0;
    localparam logic [63:0] RST_KEPT_COLUMNS     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0]  fld_sep;
        logic [7:0]  coll_sep;
        logic [7:0]  record_delim;
        logic [7:0]  escape_byte;
        logic [7:0]  quote_byte;
        logic        quotes_enabled;
        logic [63:0] kept_columns;
    } t_cfg;

    typedef struct packed {
        logic        field_end;
        logic        record_end;
        logic [5:0]  column_index;
        logic        column_kept;
        logic [15:0] field_length;
        logic        field_is_empty;
        logic        field_needs_unescape;
        logic        too_many_columns;
    } t_result;

endpackage

// ===== src/dtft_if.sv =====
// Handshake channels of the tokenizer: byte input, result output, config write.
// Depends on dtft_pkg for the config field widths.
interface dtft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dtft_out_if;
    logic        valid;
    logic        ready;
    logic        field_end;
    logic        record_end;
    logic [5:0]  column_index;
    logic        column_kept;
    logic [15:0] field_length;
    logic        field_is_empty;
    logic        field_needs_unescape;
    logic        too_many_columns;

    modport source (output valid, output field_end, output record_end,
                    output column_index, output column_kept, output field_length,
                    output field_is_empty, output field_needs_unescape,
                    output too_many_columns, input ready);
    modport sink   (input valid, input field_end, input record_end,
                    input column_index, input column_kept, input field_length,
                    input field_is_empty, input field_needs_unescape,
                    input too_many_columns, output ready);
endinterface

interface dtft_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [dtft_pkg::CFG_IDX_BITS-1:0]    index;
    logic [dtft_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dtft_cfg.sv =====
// Configuration register file of the tokenizer.
// Depends on dtft_pkg and dtft_cfg_if.
module dtft_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtft_cfg_if.sink      i_cfg,
    output dtft_pkg::t_cfg o_cfg
);
    import dtft_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fld_sep          <= RST_FLD_SEP;
            r_cfg.coll_sep         <= RST_COLL_SEP;
            r_cfg.record_delim     <= RST_RECORD_DELIM;
            r_cfg.escape_byte      <= RST_ESCAPE_BYTE;
            r_cfg.quote_byte       <= RST_QUOTE_BYTE;
            r_cfg.quotes_enabled   <= RST_QUOTES_ENABLED;
            r_cfg.kept_columns     <= RST_KEPT_COLUMNS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FLD_SEP:          r_cfg.fld_sep          <= i_cfg.data[7:0];
                REG_COLL_SEP:         r_cfg.coll_sep         <= i_cfg.data[7:0];
                REG_RECORD_DELIM:     r_cfg.record_delim     <= i_cfg.data[7:0];
                REG_ESCAPE_BYTE:      r_cfg.escape_byte      <= i_cfg.data[7:0];
                REG_QUOTE_BYTE:       r_cfg.quote_byte       <= i_cfg.data[7:0];
                REG_QUOTES_ENABLED:   r_cfg.quotes_enabled   <= i_cfg.data[0];
                REG_KEPT_COLUMNS:     r_cfg.kept_columns     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end
endmodule

// ===== src/dtft_scan.sv =====
// Byte classifier and field state of the tokenizer: forms one result per byte.
// Depends on dtft_pkg.
module dtft_scan #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtft_pkg::t_cfg    i_cfg,
    input  logic [7:0]        i_byte,
    input  logic              i_fire,
    output dtft_pkg::t_result o_result
);
    import dtft_pkg::*;

    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);

    logic                   r_esc;
    logic                   r_inq;
    logic                   r_unesc;
    logic [CW-1:0]          r_cnt;
    logic [LENGTH_BITS-1:0] r_len;

    logic                   n_esc;
    logic                   n_inq;
    logic                   n_unesc;
    logic [CW-1:0]          n_cnt;
    logic [LENGTH_BITS-1:0] n_len;

    logic        fend;
    logic        rend;
    logic        over;
    logic [6:0]  cnt7;
    logic [31:0] len_ext;

    always_comb begin
        n_esc   = r_esc;
        n_inq   = r_inq;
        n_unesc = r_unesc;
        fend    = 1'b0;
        rend    = 1'b0;
        if (!r_esc && (i_byte == i_cfg.fld_sep || i_byte == i_cfg.coll_sep)) begin
            fend = !r_inq;
        end else if (!r_esc && i_byte == i_cfg.record_delim) begin
            fend = !r_inq;
            rend = !r_inq;
        end else if (i_cfg.quotes_enabled && i_byte == i_cfg.quote_byte) begin
            if (!r_inq) begin
                n_inq = 1'b1;
            end else if (r_esc) begin
                n_unesc = 1'b1;
            end else begin
                n_inq = 1'b0;
            end
            n_esc = 1'b0;
        end else if (i_byte == i_cfg.escape_byte) begin
            n_esc = !r_esc;
        end else begin
            n_esc = 1'b0;
        end

        cnt7    = 7'(r_cnt);
        over    = cnt7 >= 7'(MAX_COLUMNS);
        len_ext = 32'(r_len);

        o_result = '0;
        if (fend) begin
            o_result.field_end            = 1'b1;
            o_result.record_end           = rend;
            o_result.column_index         = (cnt7 > 7'd63) ? 6'd63 : cnt7[5:0];
            o_result.column_kept          = !over && i_cfg.kept_columns[cnt7[5:0]];
            o_result.field_length         = (len_ext > 32'd65535) ? 16'hFFFF : len_ext[15:0];
            o_result.field_is_empty       = (r_len == '0);
            o_result.field_needs_unescape = r_unesc;
            o_result.too_many_columns     = over;
        end

        n_len = r_len;
        n_cnt = r_cnt;
        if (fend) begin
            n_len   = '0;
            n_unesc = 1'b0;
            if (rend) begin
                n_cnt = '0;
            end else if (!over) begin
                n_cnt = r_cnt + CW'(1);
            end
        end else if (r_len != '1) begin
            n_len = r_len + LENGTH_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_inq   <= 1'b0;
            r_unesc <= 1'b0;
            r_cnt   <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_esc   <= n_esc;
            r_inq   <= n_inq;
            r_unesc <= n_unesc;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
        end
    end
endmodule

// ===== src/delimited_text_field_tokenizer_core.sv =====
// Delimited text tokenizer: one byte in, one result out, one byte per cycle.
// An accepted byte is held in the input register, then its result is registered
// in the result register and presented from there until it is taken.
// Throughput: one byte per cycle, set by the state update between the two
// registers; a stalled result holds the input register and, once it is full, blocks new bytes.
// Reset (synchronous, active low) clears both valid flags and the field state.
module delimited_text_field_tokenizer_core #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtft_in_if.sink    i_in,
    dtft_cfg_if.sink   i_cfg,
    dtft_out_if.source o_out
);
    import dtft_pkg::*;

    t_cfg       cfg;
    t_result    res;
    logic       advance;
    logic       fire;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    dtft_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    dtft_scan #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_byte   (r_in_byte),
        .i_fire   (fire),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.field_end            = r_out.field_end;
    assign o_out.record_end           = r_out.record_end;
    assign o_out.column_index         = r_out.column_index;
    assign o_out.column_kept          = r_out.column_kept;
    assign o_out.field_length         = r_out.field_length;
    assign o_out.field_is_empty       = r_out.field_is_empty;
    assign o_out.field_needs_unescape = r_out.field_needs_unescape;
    assign o_out.too_many_columns     = r_out.too_many_columns;
endmodule

// ===== src/dtft_checker.sv =====
// Port-level checker of the tokenizer, bound to the top level.
// Depends on delimited_text_field_tokenizer_core_assert.svh.
`include "delimited_text_field_tokenizer_core_assert.svh"

module dtft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_field_end,
    input logic        i_record_end,
    input logic [5:0]  i_column_index,
    input logic        i_column_kept,
    input logic [15:0] i_field_length,
    input logic        i_field_is_empty,
    input logic        i_field_needs_unescape,
    input logic        i_too_many_columns
);
    `DTFT_ASSERT_IMP(a_record_implies_field, i_clk, i_rst_n, i_valid && i_record_end, i_field_end)
    `DTFT_ASSERT_IMP(a_empty_matches_length, i_clk, i_rst_n, i_valid && i_field_end, i_field_is_empty == (i_field_length == 16'd0))
    `DTFT_ASSERT_IMP(a_no_end_all_zero, i_clk, i_rst_n, i_valid && !i_field_end, !i_record_end && i_column_index == 6'd0 && !i_column_kept && i_field_length == 16'd0 && !i_field_is_empty && !i_field_needs_unescape && !i_too_many_columns)
    `DTFT_ASSERT_IMP(a_overflow_not_kept, i_clk, i_rst_n, i_valid && i_too_many_columns, !i_column_kept && i_column_index == 6'd63)
    `DTFT_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_field_end) && $stable(i_field_length) && $stable(i_column_index))
endmodule

bind delimited_text_field_tokenizer_core dtft_checker u_dtft_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_valid                (o_out.valid),
    .i_ready                (o_out.ready),
    .i_field_end            (o_out.field_end),
    .i_record_end           (o_out.record_end),
    .i_column_index         (o_out.column_index),
    .i_column_kept          (o_out.column_kept),
    .i_field_length         (o_out.field_length),
    .i_field_is_empty       (o_out.field_is_empty),
    .i_field_needs_unescape (o_out.field_needs_unescape),
    .i_too_many_columns     (o_out.too_many_columns)
);

// ===== verif/delimited_text_field_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for delimited_text_field_tokenizer_core: a directed table,
// one long field in a burst, then random record streams under random configs.
// Depends on dtft_pkg, the dtft_*_if interfaces and the core itself.
module delimited_text_field_tokenizer_core_tb;
    import dtft_pkg::*;

    localparam logic [6:0]  MAX_COLS      = 7'd64;
    localparam int          RANDOM_BYTES  = 1500;
    localparam int          LONG_FIELD    = 300;
    localparam int          LATENCY_SLACK = 6;
    localparam longint      CYCLE_LIMIT   = 2000000;

    localparam logic [7:0] B_COMMA = 8'h2C;
    localparam logic [7:0] B_SEMI  = 8'h3B;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_BSL   = 8'h5C;
    localparam logic [7:0] B_DQ    = 8'h22;
    localparam logic [7:0] B_SQ    = 8'h27;

    typedef struct {
        bit          cfg_row;
        t_reg_idx    reg_sel;
        logic [63:0] reg_val;
        logic [7:0]  data_byte;
        bit          has_lit;
        t_result     lit;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    dtft_in_if  in_ch ();
    dtft_out_if out_ch ();
    dtft_cfg_if cfg_ch ();

    delimited_text_field_tokenizer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_cfg        cfg_q;
    logic        esc_pend;
    logic        in_quote;
    logic        unesc;
    logic [6:0]  col_cnt;
    logic [15:0] fld_len;

    t_result     tokens_due[$];
    logic [7:0]  text_q[$];
    int          bad_tokens   = 0;
    int          stall_left   = 0;
    int          random_bytes = 0;
    bit          no_idle      = 1'b0;
    longint      cycle_cnt    = 0;

    t_dir_row dir_rows [30] = '{
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b1,
          '{1'b1, 1'b0, 6'd0, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0}},
        '{1'b0, REG_FLD_SEP, 64'd0, 8'h00, 1'b1, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, 8'hFF, 1'b1, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_LF, 1'b1,
          '{1'b1, 1'b1, 6'd1, 1'b1, 16'd2, 1'b0, 1'b0, 1'b0}},
        '{1'b0, REG_FLD_SEP, 64'd0, B_BSL, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_BSL, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_BSL, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b0, '0},
        '{1'b1, REG_QUOTES_ENABLED, 64'd1, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_DQ, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_BSL, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_DQ, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_DQ, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_LF, 1'b0, '0},
        '{1'b1, REG_KEPT_COLUMNS, 64'd0, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b1,
          '{1'b1, 1'b0, 6'd0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0}},
        '{1'b1, REG_FLD_SEP, 64'h00, 8'h00, 1'b0, '0},
        '{1'b1, REG_COLL_SEP, 64'hFF, 8'h00, 1'b0, '0},
        '{1'b1, REG_RECORD_DELIM, 64'h2C, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, 8'hFF, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b0, '0},
        '{1'b1, REG_ESCAPE_BYTE, 64'h27, 8'h00, 1'b0, '0},
        '{1'b1, REG_QUOTE_BYTE, 64'h27, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_SQ, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, 8'h00, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_SQ, 1'b0, '0},
        '{1'b0, REG_FLD_SEP, 64'd0, B_COMMA, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_result tokenize_byte(input logic [7:0] c);
        t_result r;
        logic    fend;
        logic    rend;
        logic    over;
        r    = '0;
        fend = 1'b0;
        rend = 1'b0;
        if (!esc_pend && (c == cfg_q.fld_sep || c == cfg_q.coll_sep)) begin
            fend = !in_quote;
        end else if (!esc_pend && c == cfg_q.record_delim) begin
            fend = !in_quote;
            rend = !in_quote;
        end else if (cfg_q.quotes_enabled && c == cfg_q.quote_byte) begin
            if (!in_quote)
                in_quote = 1'b1;
            else if (esc_pend)
                unesc = 1'b1;
            else
                in_quote = 1'b0;
            esc_pend = 1'b0;
        end else if (c == cfg_q.escape_byte) begin
            esc_pend = !esc_pend;
        end else begin
            esc_pend = 1'b0;
        end

        if (fend) begin
            over = (col_cnt >= MAX_COLS);
            r.field_end            = 1'b1;
            r.record_end           = rend;
            r.column_index         = (col_cnt > 7'd63) ? 6'd63 : col_cnt[5:0];
            r.column_kept          = !over && cfg_q.kept_columns[col_cnt[5:0]];
            r.field_length         = fld_len;
            r.field_is_empty       = (fld_len == 16'd0);
            r.field_needs_unescape = unesc;
            r.too_many_columns     = over;
            fld_len = '0;
            unesc   = 1'b0;
            if (col_cnt < MAX_COLS)
                col_cnt++;
            if (rend)
                col_cnt = '0;
        end else if (fld_len != 16'hFFFF) begin
            fld_len++;
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cfg_q.fld_sep || b == cfg_q.coll_sep ||
               b == cfg_q.record_delim || b == cfg_q.escape_byte ||
               (cfg_q.quotes_enabled && b == cfg_q.quote_byte));
        return b;
    endfunction

    function automatic logic [7:0] pick_reg8(input logic [7:0] dflt);
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3, 4: return dflt;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void stash_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    task automatic cmp_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            bad_tokens++;
        end
    endtask

    task automatic match_token();
        t_result want;
        if (tokens_due.size() == 0) begin
            $error("result beat with no byte outstanding");
            bad_tokens++;
        end else begin
            want = tokens_due.pop_front();
            cmp_field("field_end", 16'(want.field_end), 16'(out_ch.field_end));
            cmp_field("record_end", 16'(want.record_end), 16'(out_ch.record_end));
            cmp_field("column_index", 16'(want.column_index),
                      16'(out_ch.column_index));
            cmp_field("column_kept", 16'(want.column_kept), 16'(out_ch.column_kept));
            cmp_field("field_length", want.field_length, out_ch.field_length);
            cmp_field("field_is_empty", 16'(want.field_is_empty),
                      16'(out_ch.field_is_empty));
            cmp_field("field_needs_unescape", 16'(want.field_needs_unescape),
                      16'(out_ch.field_needs_unescape));
            cmp_field("too_many_columns", 16'(want.too_many_columns),
                      16'(out_ch.too_many_columns));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            match_token();
            stall_left = no_idle ? 0 : $urandom_range(0, 18);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    task automatic feed_byte(input logic [7:0] b, input bit has_lit, input t_result lit);
        int      gap;
        t_result pred;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = tokenize_byte(b);
        if (has_lit)
            pred = lit;
        tokens_due = {tokens_due, pred};
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx sel, input logic [63:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = sel;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (sel)
            REG_FLD_SEP:          cfg_q.fld_sep          = val[7:0];
            REG_COLL_SEP:         cfg_q.coll_sep         = val[7:0];
            REG_RECORD_DELIM:     cfg_q.record_delim     = val[7:0];
            REG_ESCAPE_BYTE:      cfg_q.escape_byte      = val[7:0];
            REG_QUOTE_BYTE:       cfg_q.quote_byte       = val[7:0];
            REG_QUOTES_ENABLED:   cfg_q.quotes_enabled   = val[0];
            REG_KEPT_COLUMNS:     cfg_q.kept_columns     = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic roll_config();
        logic [63:0] mask;
        case ($urandom_range(0, 3))
            0:       mask = '0;
            1:       mask = '1;
            default: mask = {$urandom, $urandom};
        endcase
        write_reg(REG_FLD_SEP, pick_reg8(RST_FLD_SEP));
        write_reg(REG_COLL_SEP, pick_reg8(B_SEMI));
        write_reg(REG_RECORD_DELIM, pick_reg8(RST_RECORD_DELIM));
        write_reg(REG_ESCAPE_BYTE, pick_reg8(RST_ESCAPE_BYTE));
        write_reg(REG_QUOTE_BYTE, pick_reg8(RST_QUOTE_BYTE));
        write_reg(REG_QUOTES_ENABLED, 64'($urandom_range(0, 3) != 0));
        write_reg(REG_KEPT_COLUMNS, mask);
    endtask

    task automatic build_record(input bit wide);
        int nf;
        int f;
        nf = wide ? $urandom_range(62, 70) : $urandom_range(1, 8);
        for (f = 0; f < nf; f++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(0, 6)) stash_byte(pick_plain());
                end
                5, 6: begin
                    stash_byte(cfg_q.quote_byte);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 5))
                            0: stash_byte(cfg_q.fld_sep);
                            1: stash_byte(cfg_q.record_delim);
                            2: begin
                                stash_byte(cfg_q.escape_byte);
                                stash_byte(cfg_q.quote_byte);
                            end
                            3: stash_byte(cfg_q.escape_byte);
                            default: stash_byte(pick_plain());
                        endcase
                    end
                    if ($urandom_range(0, 9) != 0)
                        stash_byte(cfg_q.quote_byte);
                end
                7: begin
                    stash_byte(cfg_q.escape_byte);
                    stash_byte($urandom_range(0, 1) ? cfg_q.fld_sep
                                                    : cfg_q.record_delim);
                    stash_byte(pick_plain());
                end
                8: begin
                    stash_byte(cfg_q.escape_byte);
                    stash_byte(cfg_q.escape_byte);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) stash_byte(8'($urandom_range(0, 255)));
                end
            endcase
            if (f < nf - 1)
                stash_byte($urandom_range(0, 1) ? cfg_q.fld_sep : cfg_q.coll_sep);
            else
                stash_byte(cfg_q.record_delim);
        end
    endtask

    task automatic run_phase();
        int budget;
        bit wide;
        drain_results();
        roll_config();
        wide    = ($urandom_range(0, 3) == 0);
        no_idle = ($urandom_range(0, 3) == 0);
        budget  = $urandom_range(80, 220);
        while (budget > 0) begin
            build_record(wide);
            while (text_q.size() != 0) begin
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                feed_byte(text_q.pop_front(), 1'b0, '0);
                budget--;
                random_bytes++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_FLD_SEP;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        cfg_q = '{fld_sep: RST_FLD_SEP, coll_sep: RST_COLL_SEP,
                  record_delim: RST_RECORD_DELIM, escape_byte: RST_ESCAPE_BYTE,
                  quote_byte: RST_QUOTE_BYTE, quotes_enabled: RST_QUOTES_ENABLED,
                  kept_columns: RST_KEPT_COLUMNS};
        esc_pend = 1'b0;
        in_quote = 1'b0;
        unesc    = 1'b0;
        col_cnt  = '0;
        fld_len  = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_row) begin
                drain_results();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            end else begin
                feed_byte(dir_rows[i].data_byte, dir_rows[i].has_lit, dir_rows[i].lit);
            end
        end

        // push one long field in an unbroken burst
        drain_results();
        write_reg(REG_FLD_SEP, B_COMMA);
        write_reg(REG_COLL_SEP, B_SEMI);
        write_reg(REG_RECORD_DELIM, B_LF);
        write_reg(REG_QUOTES_ENABLED, 64'd0);
        no_idle = 1'b1;
        repeat (LONG_FIELD) feed_byte(pick_plain(), 1'b0, '0);
        feed_byte(B_COMMA, 1'b0, '0);
        feed_byte(B_LF, 1'b0, '0);
        no_idle = 1'b0;

        while (random_bytes < RANDOM_BYTES) run_phase();
        drain_results();

        if (bad_tokens == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/dtft_pkg.sv
src/dtft_if.sv
src/dtft_cfg.sv
src/dtft_scan.sv
src/delimited_text_field_tokenizer_core.sv
src/dtft_checker.sv
verif/delimited_text_field_tokenizer_core_tb.sv
